@@ hw/rtl/msx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package msx_pkg;

   localparam int DMEM_WORDS = 1024;
   localparam int DMEM_AW    = $clog2(DMEM_WORDS);
   localparam int QDEPTH     = 4;
   localparam int QAW        = $clog2(QDEPTH);

   localparam logic [31:0] BOOT_PC      = 32'hBFC0_0000;
   localparam logic [1:0]  ALIGN_MASK   = 2'b11;
   localparam logic [3:0]  SEG_MASK     = 4'hF;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2B;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [4:0] COP0_MT    = 5'd4;
   localparam logic [5:0] COP0_FUNCT = 6'h00;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_OVF    = 3'd1,
      ST_LD_MIS = 3'd2,
      ST_ST_MIS = 3'd3,
      ST_UNIMP  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      K_ADD, K_ADDU, K_SLL, K_J, K_ORI, K_BEQ, K_BNE,
      K_ADDI, K_ADDIU, K_LUI, K_LW, K_SW, K_MTC0, K_BAD
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] instr;
   } qent_type;

endpackage
`default_nettype wire

@@ hw/rtl/msx_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module msx_front import msx_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr_word,
   output qent_type         head,
   output logic             head_valid,
   input  wire logic        pop
);

   qent_type           q_ff [QDEPTH];
   logic [QAW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]       cnt_ff;
   logic               push;
   kind_type           kind;
   logic [5:0]         op, fn;
   logic [4:0]         rs;

   assign op = req_instr_word[31:26];
   assign fn = req_instr_word[5:0];
   assign rs = req_instr_word[25:21];

   always_comb begin
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_ADD:  kind = K_ADD;
               FN_ADDU: kind = K_ADDU;
               FN_SLL:  kind = K_SLL;
               default: kind = K_BAD;
            endcase
         end
         OP_J:     kind = K_J;
         OP_BEQ:   kind = K_BEQ;
         OP_BNE:   kind = K_BNE;
         OP_ADDI:  kind = K_ADDI;
         OP_ADDIU: kind = K_ADDIU;
         OP_ORI:   kind = K_ORI;
         OP_LUI:   kind = K_LUI;
         OP_LW:    kind = K_LW;
         OP_SW:    kind = K_SW;
         OP_COP0:  kind = (rs == COP0_MT && fn == COP0_FUNCT) ? K_MTC0 : K_BAD;
         default:  kind = K_BAD;
      endcase
   end

   assign req_stall  = (cnt_ff == (QAW+1)'(QDEPTH));
   assign push       = req_valid && !req_stall;
   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{kind: kind, instr: req_instr_word};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/msx_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module msx_back import msx_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire qent_type    head,
   input  wire logic        head_valid,
   output logic             pop,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_next_fetch_pc,
   output logic [2:0]       rsp_status,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_write_index,
   output logic [31:0]      rsp_write_value,
   output logic             rsp_store_done,
   output logic [31:0]      rsp_store_address,
   output logic [31:0]      rsp_store_value
);

   // state
   logic [31:0] pc_ff, bt_ff;
   logic        bp_ff;
   logic [31:0] rf_ff [32];
   logic [31:0] rf_vld_ff;
   logic [31:0] cop0_ff [32];
   logic [31:0] dmem_ff [DMEM_WORDS];
   logic [31:0] dmem_q_ff;

   // execute stage
   logic        x_valid_ff;
   qent_type    x_ent_ff;
   logic [31:0] x_rs_q_ff, x_rt_q_ff;
   logic        x_rs_v_ff, x_rt_v_ff;

   // writeback / result stage
   logic        w_valid_ff, w_wr_ff, w_ld_ff, w_st_ff;
   logic [31:0] w_next_ff, w_val_ff, w_saddr_ff, w_sval_ff;
   logic [2:0]  w_status_ff;
   logic [4:0]  w_idx_ff;

   // last retired write, covers the read/write edge overlap
   logic        w2_v_ff;
   logic [4:0]  w2_idx_ff;
   logic [31:0] w2_val_ff;

   logic        adv, x_go;
   logic [31:0] w_val_eff, vs, vt, imm_sx, opb, sum, pc4, next_pc, ntarget;
   logic [4:0]  rs, rt, rd, sa;
   logic        ovf, newbr, x_wr, x_st, x_ld, cop0_we;
   logic [4:0]  x_idx;
   logic [31:0] x_val, x_saddr, x_sval;
   status_type  x_status;
   logic [DMEM_AW-1:0] dm_idx;

   assign adv  = !w_valid_ff || !rsp_stall;
   assign pop  = adv && head_valid;
   assign x_go = adv && x_valid_ff;

   assign w_val_eff = w_ld_ff ? dmem_q_ff : w_val_ff;

   assign rs = x_ent_ff.instr[25:21];
   assign rt = x_ent_ff.instr[20:16];
   assign rd = x_ent_ff.instr[15:11];
   assign sa = x_ent_ff.instr[10:6];

   always_comb begin
      if (w_valid_ff && w_wr_ff && w_idx_ff == rs) vs = w_val_eff;
      else if (w2_v_ff && w2_idx_ff == rs)         vs = w2_val_ff;
      else                                         vs = x_rs_v_ff ? x_rs_q_ff : '0;
      if (w_valid_ff && w_wr_ff && w_idx_ff == rt) vt = w_val_eff;
      else if (w2_v_ff && w2_idx_ff == rt)         vt = w2_val_ff;
      else                                         vt = x_rt_v_ff ? x_rt_q_ff : '0;
   end

   assign imm_sx  = {{16{x_ent_ff.instr[15]}}, x_ent_ff.instr[15:0]};
   assign opb     = (x_ent_ff.kind == K_ADD || x_ent_ff.kind == K_ADDU) ? vt : imm_sx;
   assign sum     = vs + opb;
   assign ovf     = ((vs[31] ^ sum[31]) & (opb[31] ^ sum[31]));
   assign pc4     = pc_ff + 32'd4;
   assign next_pc = bp_ff ? bt_ff : pc4;
   assign dm_idx  = sum[2 +: DMEM_AW];

   always_comb begin
      x_wr     = 1'b0;
      x_idx    = '0;
      x_val    = '0;
      x_st     = 1'b0;
      x_ld     = 1'b0;
      x_saddr  = '0;
      x_sval   = '0;
      x_status = ST_OK;
      newbr    = 1'b0;
      ntarget  = '0;
      cop0_we  = 1'b0;
      case (x_ent_ff.kind)
         K_ADD, K_ADDI: begin
            if (ovf) begin
               x_status = ST_OVF;
            end else begin
               x_wr  = 1'b1;
               x_idx = (x_ent_ff.kind == K_ADD) ? rd : rt;
               x_val = sum;
            end
         end
         K_ADDU: begin
            x_wr = 1'b1; x_idx = rd; x_val = sum;
         end
         K_ADDIU: begin
            x_wr = 1'b1; x_idx = rt; x_val = sum;
         end
         K_SLL: begin
            x_wr = 1'b1; x_idx = rd; x_val = vt << sa;
         end
         K_ORI: begin
            x_wr = 1'b1; x_idx = rt; x_val = vs | {16'h0000, x_ent_ff.instr[15:0]};
         end
         K_LUI: begin
            x_wr = 1'b1; x_idx = rt; x_val = {x_ent_ff.instr[15:0], 16'h0000};
         end
         K_J: begin
            newbr   = 1'b1;
            ntarget = {pc4[31:28] & SEG_MASK, x_ent_ff.instr[25:0], 2'b00};
         end
         K_BEQ, K_BNE: begin
            if ((x_ent_ff.kind == K_BEQ) == (vs == vt)) begin
               newbr   = 1'b1;
               ntarget = pc4 + {imm_sx[29:0], 2'b00};
            end
         end
         K_LW: begin
            if ((sum[1:0] & ALIGN_MASK) != 2'b00) begin
               x_status = ST_LD_MIS;
            end else begin
               x_wr = 1'b1; x_idx = rt; x_ld = 1'b1;
            end
         end
         K_SW: begin
            if ((sum[1:0] & ALIGN_MASK) != 2'b00) begin
               x_status = ST_ST_MIS;
            end else begin
               x_st = 1'b1; x_saddr = sum; x_sval = vt;
            end
         end
         K_MTC0: cop0_we = 1'b1;
         default: x_status = ST_UNIMP;
      endcase
      if (x_idx == 5'd0) begin
         x_wr = 1'b0;
         x_ld = 1'b0;
      end
      if (!x_wr) begin
         x_idx = '0;
         x_val = '0;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (pop) begin
         x_rs_q_ff <= rf_ff[head.instr[25:21]];
         x_rt_q_ff <= rf_ff[head.instr[20:16]];
      end
      if (adv && w_valid_ff && w_wr_ff) rf_ff[w_idx_ff] <= w_val_eff;
   end

   always_ff @(posedge clock) begin
      if (x_go && x_st) dmem_ff[dm_idx] <= vt;
      if (x_go && x_ld) dmem_q_ff <= dmem_ff[dm_idx];
   end

   always_ff @(posedge clock) begin
      if (x_go && cop0_we) cop0_ff[rd] <= vt;
   end

   // payload
   always_ff @(posedge clock) begin
      if (pop) begin
         x_ent_ff  <= head;
         x_rs_v_ff <= rf_vld_ff[head.instr[25:21]];
         x_rt_v_ff <= rf_vld_ff[head.instr[20:16]];
      end
      if (x_go) begin
         w_next_ff   <= next_pc;
         w_status_ff <= x_status;
         w_wr_ff     <= x_wr;
         w_ld_ff     <= x_ld;
         w_idx_ff    <= x_idx;
         w_val_ff    <= x_val;
         w_st_ff     <= x_st;
         w_saddr_ff  <= x_saddr;
         w_sval_ff   <= x_sval;
      end
      if (adv) begin
         w2_idx_ff <= w_idx_ff;
         w2_val_ff <= w_val_eff;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= BOOT_PC;
         bp_ff      <= 1'b0;
         bt_ff      <= '0;
         rf_vld_ff  <= '0;
         x_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
         w2_v_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            pc_ff <= csr_data;
            bp_ff <= 1'b0;
         end else if (x_go) begin
            pc_ff <= next_pc;
            bp_ff <= newbr;
            if (newbr) bt_ff <= ntarget;
         end
         if (adv) begin
            x_valid_ff <= head_valid;
            w_valid_ff <= x_valid_ff;
            w2_v_ff    <= w_valid_ff && w_wr_ff;
            if (w_valid_ff && w_wr_ff) rf_vld_ff[w_idx_ff] <= 1'b1;
         end
      end
   end

   assign rsp_valid         = w_valid_ff;
   assign rsp_next_fetch_pc = w_next_ff;
   assign rsp_status        = w_status_ff;
   assign rsp_reg_written   = w_wr_ff;
   assign rsp_write_index   = w_idx_ff;
   assign rsp_write_value   = w_val_eff;
   assign rsp_store_done    = w_st_ff;
   assign rsp_store_address = w_saddr_ff;
   assign rsp_store_value   = w_sval_ff;

endmodule
`default_nettype wire

@@ hw/rtl/mips1_subset_executor_unit.sv @@
// Executes a subset of MIPS-I, one instruction word per req word.
// req channel: req_valid/req_stall with req_instr_word, the instruction at
//   the current program counter. A word is taken when valid is high and
//   stall is low; a 4-entry decode queue raises req_stall only when full.
// rsp channel: rsp_valid/rsp_stall with next fetch address, status, the
//   register writeback and the store. One rsp word per req word, in order.
// csr channel: csr_valid/csr_ready (ready always high) with csr_reset_pc.
//   A write loads the program counter and drops any pending branch target;
//   issue it only with the unit idle.
// Path: a word taken from req is written into the queue, then its registers
//   are read into the execute stage, then it executes into the result stage that drives rsp.
//   Throughput: one word per cycle while rsp is not stalled; register and load
//   results forward to the next word without bubbles.
// Reset: program counter to 0xBFC00000, registers read as zero, queue and
//   pipe empty. Data memory is not cleared.
// A stall on rsp holds the result stage and execute stage; the queue keeps
//   taking req words until its four entries are full.
`timescale 1ns / 1ps
`default_nettype none
module mips1_subset_executor_unit import msx_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_next_fetch_pc,
   output logic [2:0]       rsp_status,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_write_index,
   output logic [31:0]      rsp_write_value,
   output logic             rsp_store_done,
   output logic [31:0]      rsp_store_address,
   output logic [31:0]      rsp_store_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_reset_pc
);

   qent_type head;
   logic     head_valid, pop;

   assign csr_ready = 1'b1;

   msx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_instr_word (req_instr_word),
      .head           (head),
      .head_valid     (head_valid),
      .pop            (pop)
   );

   msx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .head_valid        (head_valid),
      .pop               (pop),
      .csr_we            (csr_valid && csr_ready),
      .csr_data          (csr_reset_pc),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_fetch_pc (rsp_next_fetch_pc),
      .rsp_status        (rsp_status),
      .rsp_reg_written   (rsp_reg_written),
      .rsp_write_index   (rsp_write_index),
      .rsp_write_value   (rsp_write_value),
      .rsp_store_done    (rsp_store_done),
      .rsp_store_address (rsp_store_address),
      .rsp_store_value   (rsp_store_value)
   );

endmodule
`default_nettype wire

@@ hw/rtl/msx_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module msx_checker import msx_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_reg_written,
   input wire logic [4:0]  rsp_write_index,
   input wire logic [31:0] rsp_write_value,
   input wire logic        rsp_store_done,
   input wire logic [31:0] rsp_store_address
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_fault_no_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_reg_written && !rsp_store_done)
      else $error("faulted word has side effect");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_written |-> rsp_write_index == 5'd0 && rsp_write_value == '0)
      else $error("write fields not cleared");

   a_write_not_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_written |-> rsp_write_index != 5'd0)
      else $error("write to r0 reported");

   a_store_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_done |-> (rsp_store_address[1:0] & ALIGN_MASK) == 2'b00)
      else $error("misaligned store reported");

endmodule

bind mips1_subset_executor_unit msx_checker u_msx_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_reg_written   (rsp_reg_written),
   .rsp_write_index   (rsp_write_index),
   .rsp_write_value   (rsp_write_value),
   .rsp_store_done    (rsp_store_done),
   .rsp_store_address (rsp_store_address)
);
`default_nettype wire

@@ tb/sv/mips1_subset_executor_unit_tb.sv @@
`timescale 1ns / 1ps
module mips1_subset_executor_unit_tb import msx_pkg::*;;

   typedef struct {
      logic [31:0] npc;
      status_type  stat;
      logic        wr;
      logic [4:0]  widx;
      logic [31:0] wval;
      logic        sd;
      logic [31:0] saddr;
      logic [31:0] sval;
   } retire_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic [31:0] req_instr_word = '0;
   logic        rsp_stall = 0;
   logic        csr_valid = 0;
   logic [31:0] csr_reset_pc = '0;
   wire         req_stall, rsp_valid, csr_ready;
   wire  [31:0] rsp_next_fetch_pc, rsp_write_value, rsp_store_address, rsp_store_value;
   wire  [2:0]  rsp_status;
   wire         rsp_reg_written, rsp_store_done;
   wire  [4:0]  rsp_write_index;

   mips1_subset_executor_unit dut (.*);

   // architectural shadow state
   logic [31:0] arch_gpr [32];
   logic [31:0] arch_cop0 [32];
   logic [31:0] arch_pc;
   logic        arch_bpend;
   logic [31:0] arch_btarget;
   logic [31:0] arch_dmem [int];
   retire_type  retire_q [$];
   int          errors = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          stall_pct = 0;

   initial forever #1 clock = ~clock;

   function automatic logic [31:0] rtype(int rs, int rt, int rd, int sa, logic [5:0] fn);
      return {OP_SPECIAL, 5'(rs), 5'(rt), 5'(rd), 5'(sa), fn};
   endfunction

   function automatic logic [31:0] itype(logic [5:0] op, int rs, int rt, logic [15:0] imm);
      return {op, 5'(rs), 5'(rt), imm};
   endfunction

   function automatic logic [31:0] sext(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic add_ovf(logic [31:0] a, logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      return (a[31] == b[31]) && (s[31] != a[31]);
   endfunction

   function automatic int dmem_idx(logic [31:0] addr);
      return int'(addr >> 2) % DMEM_WORDS;
   endfunction

   // executes one word on the shadow state, returns the expected retire
   function automatic retire_type execute_word(logic [31:0] w);
      retire_type  r;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa;
      logic [31:0] vs, vt, pc, addr, tgt;
      logic        newbr;
      op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
      sa = w[10:6]; fn = w[5:0];
      vs = arch_gpr[rs]; vt = arch_gpr[rt]; pc = arch_pc;
      r = '{npc: 0, stat: ST_OK, wr: 0, widx: 0, wval: 0, sd: 0, saddr: 0, sval: 0};
      newbr = 0; tgt = 0;
      if (arch_bpend) begin
         r.npc = arch_btarget;
         arch_bpend = 0;
      end else begin
         r.npc = pc + 4;
      end
      case (op)
         OP_SPECIAL: begin
            if (fn == FN_ADD) begin
               if (add_ovf(vs, vt)) r.stat = ST_OVF;
               else begin r.wr = 1; r.widx = rd; r.wval = vs + vt; end
            end else if (fn == FN_ADDU) begin
               r.wr = 1; r.widx = rd; r.wval = vs + vt;
            end else if (fn == FN_SLL) begin
               r.wr = 1; r.widx = rd; r.wval = vt << sa;
            end else r.stat = ST_UNIMP;
         end
         OP_J: begin
            newbr = 1;
            tgt = ((pc + 4) & {SEG_MASK, 28'h0}) | {4'h0, w[25:0], 2'b00};
         end
         OP_BEQ, OP_BNE: begin
            if ((op == OP_BEQ) == (vs == vt)) begin
               newbr = 1;
               tgt = pc + 4 + (sext(w[15:0]) << 2);
            end
         end
         OP_ADDI: begin
            if (add_ovf(vs, sext(w[15:0]))) r.stat = ST_OVF;
            else begin r.wr = 1; r.widx = rt; r.wval = vs + sext(w[15:0]); end
         end
         OP_ADDIU: begin r.wr = 1; r.widx = rt; r.wval = vs + sext(w[15:0]); end
         OP_ORI:   begin r.wr = 1; r.widx = rt; r.wval = vs | {16'h0, w[15:0]}; end
         OP_LUI:   begin r.wr = 1; r.widx = rt; r.wval = {w[15:0], 16'h0}; end
         OP_LW: begin
            addr = vs + sext(w[15:0]);
            if (|(addr[1:0] & ALIGN_MASK)) r.stat = ST_LD_MIS;
            else begin
               r.wr = 1; r.widx = rt;
               r.wval = arch_dmem.exists(dmem_idx(addr)) ? arch_dmem[dmem_idx(addr)] : 0;
            end
         end
         OP_SW: begin
            addr = vs + sext(w[15:0]);
            if (|(addr[1:0] & ALIGN_MASK)) r.stat = ST_ST_MIS;
            else begin
               r.sd = 1; r.saddr = addr; r.sval = vt;
               arch_dmem[dmem_idx(addr)] = vt;
            end
         end
         OP_COP0: begin
            if (rs == COP0_MT && fn == COP0_FUNCT) arch_cop0[rd] = vt;
            else r.stat = ST_UNIMP;
         end
         default: r.stat = ST_UNIMP;
      endcase
      if (r.wr && r.widx == 0) r.wr = 0;
      if (r.wr) arch_gpr[r.widx] = r.wval;
      else begin r.widx = 0; r.wval = 0; end
      if (newbr) begin
         arch_bpend = 1;
         arch_btarget = tgt;
      end
      arch_pc = r.npc;
      return r;
   endfunction

   // points an aligned load at a stored word, or misaligns it while none is stored
   function automatic logic [31:0] fix_load(logic [31:0] w);
      logic [31:0] vs, addr;
      int          keys [$];
      int          k;
      if (w[31:26] != OP_LW) return w;
      vs = arch_gpr[w[25:21]];
      addr = vs + sext(w[15:0]);
      if (addr[1:0] != 2'b00) return w;
      foreach (arch_dmem[i]) keys.push_back(i);
      if (keys.size() == 0) begin
         w[1:0] = 2'(1 - vs[1:0]);
         return w;
      end
      k = keys[$urandom_range(0, keys.size() - 1)];
      w[11:0] = 12'((k << 2) - vs);
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_word(logic [31:0] w);
      int gap;
      req_valid <= 1;
      req_instr_word <= w;
      do @(posedge clock); while (req_stall);
      retire_q.push_back(execute_word(w));
      if (burst_left > 0) burst_left--;
      else begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(0, 30);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (retire_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reset_pc(logic [31:0] v);
      drain();
      csr_valid <= 1;
      csr_reset_pc <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      arch_pc = v;
      arch_bpend = 0;
   endtask

   // receiver: stall density changes over the run, including no stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if ($urandom_range(0, 149) == 0) stall_pct = $urandom_range(0, 3) * 25;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      retire_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (retire_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_next_fetch_pc, 0);
         end else begin
            e = retire_q.pop_front();
            if (rsp_next_fetch_pc !== e.npc)
               report_mismatch("next_fetch_pc", rsp_next_fetch_pc, e.npc);
            if (rsp_status !== e.stat) report_mismatch("status", rsp_status, e.stat);
            if (rsp_reg_written !== e.wr)
               report_mismatch("reg_written", rsp_reg_written, e.wr);
            if (rsp_write_index !== e.widx)
               report_mismatch("write_index", rsp_write_index, e.widx);
            if (rsp_write_value !== e.wval)
               report_mismatch("write_value", rsp_write_value, e.wval);
            if (rsp_store_done !== e.sd) report_mismatch("store_done", rsp_store_done, e.sd);
            if (rsp_store_address !== e.saddr)
               report_mismatch("store_address", rsp_store_address, e.saddr);
            if (rsp_store_value !== e.sval)
               report_mismatch("store_value", rsp_store_value, e.sval);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 4000) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_arith;
      send_word(itype(OP_LUI, 0, 1, 16'hFFFF));
      send_word(itype(OP_ORI, 1, 1, 16'hFFFF));
      send_word(itype(OP_LUI, 31, 2, 16'h7FFF));
      send_word(itype(OP_ORI, 2, 2, 16'hFFFF));
      send_word(rtype(2, 2, 3, 0, FN_ADD));
      send_word(rtype(2, 2, 3, 0, FN_ADDU));
      send_word(rtype(1, 1, 4, 0, FN_ADD));
      send_word(itype(OP_ADDI, 2, 5, 16'h0001));
      send_word(itype(OP_ADDI, 1, 5, 16'h8000));
      send_word(itype(OP_ADDIU, 2, 5, 16'h0001));
      send_word(rtype(0, 1, 6, 31, FN_SLL));
      send_word(rtype(0, 1, 0, 5, FN_SLL));
   endtask

   task automatic test_branches;
      send_word({OP_J, 26'h3FF_FFFF});
      send_word(itype(OP_BEQ, 0, 0, 16'hFFFF));
      send_word(itype(OP_BNE, 1, 0, 16'h7FFF));
      send_word(itype(OP_BNE, 0, 0, 16'h0004));
      send_word(itype(OP_BEQ, 1, 0, 16'h8000));
      send_word({OP_J, 26'h0});
   endtask

   task automatic test_memory;
      send_word(itype(OP_SW, 0, 1, 16'h0000));
      send_word(itype(OP_SW, 0, 2, 16'h0FFC));
      send_word(itype(OP_SW, 1, 2, 16'h0002));
      send_word(itype(OP_LW, 0, 7, 16'h1000));
      send_word(itype(OP_LW, 0, 8, 16'h0FFC));
      send_word(itype(OP_LW, 0, 8, 16'h0003));
   endtask

   task automatic test_cop0_unimp;
      send_word({OP_COP0, COP0_MT, 5'd1, 5'd12, 5'd0, COP0_FUNCT});
      send_word({OP_COP0, 5'd0, 5'd1, 5'd12, 5'd0, COP0_FUNCT});
      send_word({OP_COP0, COP0_MT, 5'd1, 5'd12, 5'd0, 6'h3F});
      send_word(32'hFFFF_FFFF);
      send_word(rtype(1, 2, 3, 0, 6'h3F));
   endtask

   task automatic test_random(int count);
      logic [31:0] w;
      logic [15:0] imm;
      int          rs, rt, rd;
      for (int i = 0; i < count; i++) begin
         w = $urandom;
         rs = $urandom_range(0, 31); rt = $urandom_range(0, 31); rd = $urandom_range(0, 31);
         imm = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 4) : 16'($urandom);
         case ($urandom_range(0, 14))
            0: w = rtype(rs, rt, rd, w[10:6], FN_ADD);
            1: w = rtype(rs, rt, rd, w[10:6], FN_ADDU);
            2: w = rtype(rs, rt, rd, w[10:6], FN_SLL);
            3: w = {OP_J, w[25:0]};
            4: w = itype(OP_ORI, rs, rt, imm);
            5: w = itype(OP_BEQ, rs, ($urandom_range(0, 1) ? rs : rt), imm);
            6: w = itype(OP_BNE, rs, ($urandom_range(0, 1) ? rs : rt), imm);
            7: w = itype(OP_ADDI, rs, rt, imm);
            8: w = itype(OP_ADDIU, rs, rt, imm);
            9: w = itype(OP_LUI, rs, rt, imm);
            10, 11: w = itype(OP_LW, rs, rt, imm);
            12: w = itype(OP_SW, rs, rt, imm);
            13: w = {OP_COP0, ($urandom_range(0, 3) ? COP0_MT : 5'(rs)), w[20:6],
                     ($urandom_range(0, 3) ? COP0_FUNCT : w[5:0])};
            default: ;
         endcase
         send_word(fix_load(w));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      for (int i = 0; i < 32; i++) begin
         arch_gpr[i] = 0;
         arch_cop0[i] = 0;
      end
      arch_pc = BOOT_PC;
      arch_bpend = 0;
      arch_btarget = 0;
      test_arith();
      test_branches();
      test_memory();
      test_cop0_unimp();
      write_reset_pc(32'h0000_0000);
      test_random(300);
      drain();
      test_random(200);
      write_reset_pc(32'hFFFF_FFFC);
      test_random(300);
      write_reset_pc(32'hFFFF_FFFF);
      test_random(200);
      write_reset_pc($urandom);
      test_random(300);
      drain();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
